// File: rtl/cbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbq_pkg;

  // Default sizes of the filter bank.
  localparam int DEF_BANDS       = 8;
  localparam int DEF_COEF_WIDTH  = 32;
  localparam int DEF_STATE_WIDTH = 40;

  // Coefficients held for each band: b0, b1, b2, a1, a2.
  localparam int NSLOT     = 5;
  // Bands that have a bit in the enable mask.
  localparam int MASK_BITS = 8;

  // Payload widths of the channels.
  localparam int OPCODE_W     = 2;
  localparam int SAMPLE_W     = 16;
  localparam int BAND_SEL_W   = 3;
  localparam int SLOT_SEL_W   = 3;
  localparam int COEF_IN_W    = 32;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int BAND_LIMIT_W = 4;

  // Operations carried by an input word.
  localparam logic [OPCODE_W-1:0] OP_FILTER     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_COEF = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_LIMIT  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_ENABLE = 4'd1;

  // Coefficient slots within a band.
  localparam logic [SLOT_SEL_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_SEL_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_SEL_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_SEL_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_SEL_W-1:0] SLOT_A2 = 3'd4;

  // Program counter of the sequencer and its fixed entry points.
  localparam int UC_PC_W = 4;
  localparam logic [UC_PC_W-1:0] PC_TEST     = 4'd0;
  localparam logic [UC_PC_W-1:0] PC_LOOP     = 4'd13;
  localparam logic [UC_PC_W-1:0] PC_OUT_MUL  = 4'd14;
  localparam logic [UC_PC_W-1:0] PC_OUT_EMIT = 4'd15;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LO,
    MUL_HI
  } mul_e;

  typedef enum logic [1:0] {
    PP_NONE,
    PP_LOAD,
    PP_ADD
  } pp_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD_P,
    ACC_ADD_P,
    ACC_SUB_P,
    ACC_ADD_D1,
    ACC_ADD_D2
  } acc_e;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_Y,
    WB_D1,
    WB_D2
  } wb_e;

  typedef enum logic [1:0] {
    CTL_NEXT,
    CTL_TEST,
    CTL_LOOP,
    CTL_EMIT
  } ctl_e;

  // One control word of the sequencer.
  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_SEL_W-1:0] rd_slot;
    mul_e                  mul;
    logic                  opnd_y;
    pp_e                   pp;
    acc_e                  acc1;
    acc_e                  acc2;
    wb_e                   wb;
    ctl_e                  ctl;
  } uop_t;

  // Control store. Each product takes a low and a high partial product on the
  // shared multiplier, begun while the one before is summed. The coefficient
  // read is issued in the step before the multiplier uses it. Accumulator one
  // builds y, then the new first delay; accumulator two the new second delay.
  function automatic uop_t ucode(input logic [UC_PC_W-1:0] pc);
    uop_t u;
    u = '{rd_en: 1'b0, rd_slot: SLOT_B0, mul: MUL_NONE, opnd_y: 1'b0, pp: PP_NONE,
          acc1: ACC_NONE, acc2: ACC_NONE, wb: WB_NONE, ctl: CTL_NEXT};
    case (pc)
      4'd0: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_B0; u.ctl = CTL_TEST;
      end
      4'd1: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_B0; u.mul = MUL_LO;
      end
      4'd2: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_B1; u.mul = MUL_HI; u.pp = PP_LOAD;
      end
      4'd3: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_B1; u.mul = MUL_LO; u.pp = PP_ADD;
      end
      4'd4: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_B2; u.mul = MUL_HI; u.pp = PP_LOAD;
        u.acc1 = ACC_LOAD_P;
      end
      4'd5: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_B2; u.mul = MUL_LO; u.pp = PP_ADD;
        u.acc1 = ACC_ADD_D1;
      end
      4'd6: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_A1; u.mul = MUL_HI; u.pp = PP_LOAD;
        u.acc1 = ACC_LOAD_P; u.wb = WB_Y;
      end
      4'd7: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_A1; u.mul = MUL_LO; u.opnd_y = 1'b1;
        u.pp = PP_ADD; u.acc1 = ACC_ADD_D2;
      end
      4'd8: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_A2; u.mul = MUL_HI; u.opnd_y = 1'b1;
        u.pp = PP_LOAD; u.acc2 = ACC_LOAD_P;
      end
      4'd9: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_A2; u.mul = MUL_LO; u.opnd_y = 1'b1;
        u.pp = PP_ADD;
      end
      4'd10: begin
        u.mul = MUL_HI; u.opnd_y = 1'b1; u.pp = PP_LOAD; u.acc1 = ACC_SUB_P;
      end
      4'd11: begin
        u.pp = PP_ADD; u.wb = WB_D1;
      end
      4'd12: begin
        u.acc2 = ACC_SUB_P;
      end
      4'd13: begin
        u.wb = WB_D2; u.ctl = CTL_LOOP;
      end
      4'd14: begin
        u.ctl = CTL_NEXT;
      end
      4'd15: begin
        u.ctl = CTL_EMIT;
      end
      default: begin
        u.ctl = CTL_NEXT;
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cbq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one word is a filter request, a coefficient write or a clear.
interface cbq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cbq_pkg::OPCODE_W-1:0]         opcode;
  logic signed [cbq_pkg::SAMPLE_W-1:0]  sample_in;
  logic                                 block_end;
  logic [cbq_pkg::BAND_SEL_W-1:0]       coef_band;
  logic [cbq_pkg::SLOT_SEL_W-1:0]       coef_slot;
  logic signed [cbq_pkg::COEF_IN_W-1:0] coef_value;

  modport source (
    output valid, opcode, sample_in, block_end, coef_band, coef_slot, coef_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, sample_in, block_end, coef_band, coef_slot, coef_value,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/cbq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Output channel: one filtered sample per filter request.
interface cbq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out;
  logic                                block_end_out;

  modport source (
    output valid, sample_out, block_end_out,
    input  ready
  );

  modport sink (
    input  valid, sample_out, block_end_out,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/cbq_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Configuration write channel.
interface cbq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbq_pkg::CFG_INDEX_W-1:0]  reg_index;
  logic [cbq_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (
    output valid, reg_index, wdata,
    input  ready
  );

  modport sink (
    input  valid, reg_index, wdata,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/cascaded_biquad_equalizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Cascaded biquad equaliser, transposed direct form II, with a Q9.31 signal
// path that saturates and Q4.28 coefficients. A filter word runs its sample
// through every band below band_limit whose enable bit is set and returns one
// output word; a coefficient write or a delay clear gives none. A filter word
// keeps the block busy through its bands, applied or skipped, and any wait for
// the output register to drain: the five products of a band go through one
// shared multiplier, each as two partial products, stepped by a 16-step
// microcode program. The next word is taken as soon as a result is loaded into
// the output register, even while that result still waits to be taken.
module cascaded_biquad_equalizer #(
  parameter int BANDS       = cbq_pkg::DEF_BANDS,
  parameter int COEF_WIDTH  = cbq_pkg::DEF_COEF_WIDTH,
  parameter int STATE_WIDTH = cbq_pkg::DEF_STATE_WIDTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  cbq_in_if.sink      in_i,
  cbq_out_if.source   out_o,
  cbq_cfg_if.sink     cfg_i
);

  localparam int SW      = STATE_WIDTH;
  localparam int CW      = COEF_WIDTH;
  localparam int SF      = SW - 9;
  localparam int CF      = CW - 4;
  localparam int LO_W    = SW / 2;
  localparam int HI_W    = SW - LO_W;
  localparam int OPW     = LO_W + 1;
  localparam int MW      = CW + OPW;
  localparam int PW      = CW + SW;
  localparam int AW      = SW + 2;
  localparam int XW      = SW + 4;
  localparam int OW      = SF + 17;
  localparam int NCOEF   = BANDS * cbq_pkg::NSLOT;
  localparam int CADDR_W = $clog2(NCOEF);
  localparam int BAND_W  = $clog2(BANDS + 1);
  localparam int BIDX_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int ACW     = (BAND_W + 3 > 6) ? BAND_W + 3 : 6;
  localparam int SAMPLE_OUT_W = cbq_pkg::SAMPLE_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Saturate a widened value to the signal range.
  function automatic logic signed [SW-1:0] sat_sig(input logic signed [XW-1:0] v);
    logic signed [SW-1:0] r;
    if (v[XW-1:SW-1] != {(XW - SW + 1){v[XW-1]}}) begin
      r = {v[XW-1], {(SW - 1){~v[XW-1]}}};
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // Next value of an accumulator.
  function automatic logic signed [AW-1:0] acc_next(
    input cbq_pkg::acc_e       op,
    input logic signed [AW-1:0] a,
    input logic signed [SW-1:0] p,
    input logic signed [SW-1:0] d1,
    input logic signed [SW-1:0] d2
  );
    logic signed [AW-1:0] r;
    case (op)
      cbq_pkg::ACC_LOAD_P: r = AW'(p);
      cbq_pkg::ACC_ADD_P:  r = a + AW'(p);
      cbq_pkg::ACC_SUB_P:  r = a - AW'(p);
      cbq_pkg::ACC_ADD_D1: r = a + AW'(d1);
      cbq_pkg::ACC_ADD_D2: r = a + AW'(d2);
      default:             r = a;
    endcase
    return r;
  endfunction

  // Control state.
  logic [0:0]                    state_q, state_d;
  logic [cbq_pkg::UC_PC_W-1:0]   pc_q, pc_d;
  logic [BAND_W-1:0]             band_q, band_d;
  logic                          out_valid_q, out_valid_d;
  logic [cbq_pkg::BAND_LIMIT_W-1:0] band_limit_q;
  logic [cbq_pkg::MASK_BITS-1:0] band_mask_q;
  logic                          emit;
  logic                          start;

  // Datapath.
  logic signed [SW-1:0]          x_q, y_q;
  logic signed [CW-1:0]          coef_q;
  logic signed [MW-1:0]          mul_q, mul_d;
  logic signed [PW-1:0]          pp_q, pp_d;
  logic signed [AW-1:0]          acc1_q, acc1_d, acc2_q, acc2_d;
  logic signed [OW-1:0]          oprod_q;
  logic signed [SAMPLE_OUT_W-1:0] sample_out_q;
  logic                          block_end_q;
  logic                          block_end_out_q;
  logic signed [SW-1:0]          d1_q [BANDS];
  logic signed [SW-1:0]          d2_q [BANDS];
  logic [CW-1:0]                 coef_mem [NCOEF];

  cbq_pkg::uop_t                 uop;
  logic                          run;
  logic                          in_ready;
  logic                          in_acc;
  logic                          band_done;
  logic                          band_in_mask;
  logic [cbq_pkg::MASK_BITS-1:0] mask_sh;
  logic [BIDX_W-1:0]             bidx;
  logic signed [SW-1:0]          d1_rd, d2_rd;
  logic signed [SW-1:0]          mul_src;
  logic signed [HI_W-1:0]        src_hi;
  logic signed [OPW-1:0]         opnd;
  logic signed [XW-1:0]          p_wide;
  logic signed [SW-1:0]          p_sat;
  logic signed [SW-1:0]          y_sat, d1_sat, d2_sat;
  logic [ACW-1:0]                waddr_full, raddr_full;
  logic                          coef_we;
  logic                          rd_en;
  logic signed [SW-1:0]          x_init;
  logic signed [SW-1:0]          one_sig;
  logic signed [SW-1:0]          x_clamp;
  logic signed [OW-1:0]          x_ext;
  logic signed [OW-1:0]          oprod_d;
  logic signed [OW-1:0]          obias;

  // Handshake and band bookkeeping.
  assign in_ready     = (state_q == ST_IDLE);
  assign in_i.ready   = in_ready;
  assign in_acc       = in_i.valid && in_ready;
  assign cfg_i.ready  = 1'b1;
  assign run          = (state_q == ST_RUN);
  assign uop          = cbq_pkg::ucode(pc_q);
  assign mask_sh      = band_mask_q >> band_q;
  assign band_in_mask = (ACW'(band_q) < ACW'(cbq_pkg::MASK_BITS)) && mask_sh[0];
  assign band_done    = (ACW'(band_q) >= ACW'(BANDS)) || (ACW'(band_q) >= ACW'(band_limit_q));
  assign bidx         = band_q[BIDX_W-1:0];
  assign d1_rd        = d1_q[bidx];
  assign d2_rd        = d2_q[bidx];

  // Sequencer: step counter, band counter and conditional jumps.
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    band_d      = band_q;
    out_valid_d = out_valid_q;
    emit        = 1'b0;
    start       = 1'b0;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.opcode == cbq_pkg::OP_FILTER)) begin
          start   = 1'b1;
          state_d = ST_RUN;
          pc_d    = cbq_pkg::PC_TEST;
          band_d  = '0;
        end
      end
      ST_RUN: begin
        case (uop.ctl)
          cbq_pkg::CTL_TEST: begin
            if (band_done) begin
              pc_d = cbq_pkg::PC_OUT_MUL;
            end else if (!band_in_mask) begin
              band_d = band_q + BAND_W'(1);
            end else begin
              pc_d = pc_q + cbq_pkg::UC_PC_W'(1);
            end
          end
          cbq_pkg::CTL_LOOP: begin
            band_d = band_q + BAND_W'(1);
            pc_d   = cbq_pkg::PC_TEST;
          end
          cbq_pkg::CTL_EMIT: begin
            if (!out_valid_q || out_o.ready) begin
              emit        = 1'b1;
              out_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          default: begin
            pc_d = pc_q + cbq_pkg::UC_PC_W'(1);
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= cbq_pkg::PC_TEST;
      band_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      band_q      <= band_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_limit_q <= '0;
      band_mask_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        cbq_pkg::REG_BAND_LIMIT:  band_limit_q <= cfg_i.wdata[cbq_pkg::BAND_LIMIT_W-1:0];
        cbq_pkg::REG_BAND_ENABLE: band_mask_q  <= cfg_i.wdata[cbq_pkg::MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient store: written by coefficient words, read in the step before use.
  assign waddr_full = ACW'({in_i.coef_band, 2'b00}) + ACW'(in_i.coef_band)
                    + ACW'(in_i.coef_slot);
  assign raddr_full = ACW'({band_q, 2'b00}) + ACW'(band_q) + ACW'(uop.rd_slot);
  assign coef_we    = in_acc && (in_i.opcode == cbq_pkg::OP_WRITE_COEF)
                    && (ACW'(in_i.coef_band) < ACW'(BANDS))
                    && (ACW'(in_i.coef_slot) < ACW'(cbq_pkg::NSLOT));
  assign rd_en      = run && uop.rd_en && (ACW'(band_q) < ACW'(BANDS));

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[waddr_full[CADDR_W-1:0]] <= in_i.coef_value[cbq_pkg::COEF_IN_W-1 -: CW];
    end
    if (rd_en) begin
      coef_q <= coef_mem[raddr_full[CADDR_W-1:0]];
    end
  end

  // Multiplier operand: low half unsigned, high half signed.
  assign mul_src = uop.opnd_y ? y_q : x_q;
  assign src_hi  = mul_src[SW-1:LO_W];
  always_comb begin
    if (uop.mul == cbq_pkg::MUL_HI) begin
      opnd = OPW'(src_hi);
    end else begin
      opnd = {1'b0, mul_src[LO_W-1:0]};
    end
  end

  // Partial product, product assembly and the accumulators.
  assign mul_d  = coef_q * opnd;
  assign p_wide = pp_q[PW-1:CF];
  assign p_sat  = sat_sig(p_wide);
  assign y_sat  = sat_sig(XW'(acc1_q));
  assign d1_sat = sat_sig(XW'(acc1_q));
  assign d2_sat = sat_sig(XW'(acc2_q));

  always_comb begin
    case (uop.pp)
      cbq_pkg::PP_LOAD: pp_d = PW'(mul_q);
      cbq_pkg::PP_ADD:  pp_d = pp_q + (PW'(mul_q) <<< LO_W);
      default:          pp_d = pp_q;
    endcase
  end

  assign acc1_d = acc_next(uop.acc1, acc1_q, p_sat, d1_rd, d2_rd);
  assign acc2_d = acc_next(uop.acc2, acc2_q, p_sat, d1_rd, d2_rd);

  // Sample widened to the signal format.
  assign x_init = SW'(in_i.sample_in) <<< (SF - 15);

  // Output scaling: clamp to one, times 32767, then divide by one toward zero.
  assign one_sig = SW'(1) <<< SF;
  always_comb begin
    if (x_q > one_sig) begin
      x_clamp = one_sig;
    end else if (x_q < -one_sig) begin
      x_clamp = -one_sig;
    end else begin
      x_clamp = x_q;
    end
  end
  assign x_ext   = OW'(x_clamp);
  assign oprod_d = (x_ext <<< 15) - x_ext;
  assign obias   = oprod_q + (oprod_q[OW-1] ? ((OW'(1) <<< SF) - OW'(1)) : OW'(0));

  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q         <= x_init;
      block_end_q <= in_i.block_end;
    end else if (run && (uop.ctl == cbq_pkg::CTL_LOOP)) begin
      x_q <= y_q;
    end
    if (run) begin
      if (uop.mul != cbq_pkg::MUL_NONE) begin
        mul_q <= mul_d;
      end
      pp_q   <= pp_d;
      acc1_q <= acc1_d;
      acc2_q <= acc2_d;
      if (uop.wb == cbq_pkg::WB_Y) begin
        y_q <= y_sat;
      end
      if (pc_q == cbq_pkg::PC_OUT_MUL) begin
        oprod_q <= oprod_d;
      end
    end
    if (emit) begin
      sample_out_q    <= obias[SF+SAMPLE_OUT_W-1:SF];
      block_end_out_q <= block_end_q;
    end
  end

  // Delay states: written back at the end of a band, cleared by a clear word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BANDS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (in_acc && (in_i.opcode == cbq_pkg::OP_CLEAR)) begin
      for (int i = 0; i < BANDS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (run) begin
      if (uop.wb == cbq_pkg::WB_D1) begin
        d1_q[bidx] <= d1_sat;
      end
      if (uop.wb == cbq_pkg::WB_D2) begin
        d2_q[bidx] <= d2_sat;
      end
    end
  end

  // Output word.
  assign out_o.valid         = out_valid_q;
  assign out_o.sample_out    = sample_out_q;
  assign out_o.block_end_out = block_end_out_q;

  // A band body only runs for a band that is in range and enabled.
  a_body_band_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && (pc_q != cbq_pkg::PC_TEST) && (pc_q < cbq_pkg::PC_OUT_MUL))
      |-> (!band_done && band_in_mask))
    else $error("band body running for a band that is not applied");

  // The band counter never passes the number of bands.
  a_band_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (ACW'(band_q) <= ACW'(BANDS)))
    else $error("band counter beyond the band count");

  // A result appears only from the emit step of the program.
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(run && (pc_q == cbq_pkg::PC_OUT_EMIT)))
    else $error("output word raised outside the emit step");

endmodule

`default_nettype wire

// File: sim/cbq_response_check.sv
`timescale 1ns / 1ps

// Watches the three channels of the equaliser. It keeps its own copy of the
// registers, coefficients and delays, works out the output word for each
// accepted filter word, and compares each output word with the oldest one.
module cbq_response_check
  import cbq_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  cbq_in_if           in_i,
  cbq_out_if          out_i,
  cbq_cfg_if          cfg_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  // Number formats of the default build: Q4.28 coefficients, Q9.31 signal.
  localparam int     COEF_FRAC = DEF_COEF_WIDTH - 4;
  localparam int     SIG_FRAC  = DEF_STATE_WIDTH - 9;
  localparam longint SIG_MAX   = (longint'(1) << (DEF_STATE_WIDTH - 1)) - 1;
  localparam longint SIG_MIN   = -SIG_MAX - 1;
  localparam longint UNITY     = longint'(1) << SIG_FRAC;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } eq_result_t;

  logic [BAND_LIMIT_W-1:0] band_limit_q;
  logic [MASK_BITS-1:0]    band_mask_q;
  longint                  coef_tab [DEF_BANDS][NSLOT];
  longint                  delay_one [DEF_BANDS];
  longint                  delay_two [DEF_BANDS];
  eq_result_t              expected_q [$];
  eq_result_t              oldest;

  // Saturate a sum to the signal range.
  function automatic longint clip_signal(input longint v);
    if (v > SIG_MAX) return SIG_MAX;
    if (v < SIG_MIN) return SIG_MIN;
    return v;
  endfunction

  // Coefficient times signal, floored back to the signal format and saturated.
  function automatic longint coef_product(input longint c, input longint s);
    logic signed [127:0] wide;
    wide = c;
    wide = (wide * s) >>> COEF_FRAC;
    if (wide > SIG_MAX) return SIG_MAX;
    if (wide < SIG_MIN) return SIG_MIN;
    return longint'(wide);
  endfunction

  // Runs one sample through the enabled sections and updates their delays.
  function automatic eq_result_t filter_sample(input logic signed [SAMPLE_W-1:0] smp,
                                               input logic blk);
    longint      x;
    longint      y;
    longint      o;
    int unsigned lim;
    eq_result_t  r;
    x   = longint'(smp) <<< (SIG_FRAC - 15);
    lim = (band_limit_q < DEF_BANDS) ? band_limit_q : DEF_BANDS;
    for (int b = 0; b < lim; b++) begin
      if (b < MASK_BITS && band_mask_q[b]) begin
        y = clip_signal(coef_product(coef_tab[b][SLOT_B0], x) + delay_one[b]);
        delay_one[b] = clip_signal(coef_product(coef_tab[b][SLOT_B1], x)
                                   - coef_product(coef_tab[b][SLOT_A1], y) + delay_two[b]);
        delay_two[b] = clip_signal(coef_product(coef_tab[b][SLOT_B2], x)
                                   - coef_product(coef_tab[b][SLOT_A2], y));
        x = y;
      end
    end
    if (x > UNITY) x = UNITY;
    if (x < -UNITY) x = -UNITY;
    o = (x * 32767) / UNITY;
    r.sample    = o[SAMPLE_W-1:0];
    r.block_end = blk;
    return r;
  endfunction

  // Register writes, output checks and input predictions, in that order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_limit_q = '0;
      band_mask_q  = '0;
      for (int b = 0; b < DEF_BANDS; b++) begin
        delay_one[b] = 0;
        delay_two[b] = 0;
      end
      expected_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.reg_index)
          REG_BAND_LIMIT:  band_limit_q = cfg_i.wdata[BAND_LIMIT_W-1:0];
          REG_BAND_ENABLE: band_mask_q  = cfg_i.wdata[MASK_BITS-1:0];
          default: ;
        endcase
      end

      if (out_i.valid && out_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("sample_out: no word expected, got %0d", out_i.sample_out);
          error_count_o++;
        end else begin
          oldest = expected_q.pop_front();
          checked_o++;
          if (out_i.sample_out !== oldest.sample) begin
            $error("sample_out: expected %0d, got %0d", oldest.sample, out_i.sample_out);
            error_count_o++;
          end
          if (out_i.block_end_out !== oldest.block_end) begin
            $error("block_end_out: expected %0d, got %0d", oldest.block_end,
                   out_i.block_end_out);
            error_count_o++;
          end
        end
      end

      if (in_i.valid && in_i.ready) begin
        case (in_i.opcode)
          OP_FILTER: expected_q.push_back(filter_sample(in_i.sample_in, in_i.block_end));
          OP_WRITE_COEF: begin
            // Writes to a slot past a2 are dropped.
            if (in_i.coef_slot < NSLOT)
              coef_tab[in_i.coef_band][in_i.coef_slot] =
                longint'(in_i.coef_value) >>> (COEF_IN_W - DEF_COEF_WIDTH);
          end
          OP_CLEAR: begin
            for (int b = 0; b < DEF_BANDS; b++) begin
              delay_one[b] = 0;
              delay_two[b] = 0;
            end
          end
          default: ;
        endcase
      end

      pending_o = expected_q.size();
    end
  end

endmodule

// File: sim/cascaded_biquad_equalizer_test.sv
`timescale 1ns / 1ps

module cascaded_biquad_equalizer_test;
  import cbq_pkg::*;

  // The opcode that the block must ignore.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int IDLE_PCT        = 26;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 140;
  localparam int STALL_LIMIT     = 3000;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 124;
  localparam int STEADY_PHASE    = 2;
  localparam int HOLD_PHASE      = 5;

  logic        clk;
  logic        rst_n;
  bit          steady;
  bit          hold_pending;
  int unsigned n_filter;
  int unsigned n_coef;
  int unsigned n_clear;
  int unsigned n_ignored;
  int unsigned n_settings;
  int unsigned error_count;
  int unsigned pending;
  int unsigned checked;

  cbq_in_if  in_bus ();
  cbq_out_if out_bus ();
  cbq_cfg_if cfg_bus ();

  cascaded_biquad_equalizer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  cbq_response_check response_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_i          (in_bus),
    .out_i         (out_bus),
    .cfg_i         (cfg_bus),
    .error_count_o (error_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output side: random stalls, none in the steady phase, and one long hold-off.
  initial begin
    out_bus.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run if no word moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offers one input word, with random gaps before it, and waits for it to go.
  task automatic send_word(input logic [OPCODE_W-1:0] op,
                           input logic signed [SAMPLE_W-1:0] smp,
                           input logic blk,
                           input logic [BAND_SEL_W-1:0] band,
                           input logic [SLOT_SEL_W-1:0] slot,
                           input logic signed [COEF_IN_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.sample_in  <= smp;
    in_bus.block_end  <= blk;
    in_bus.coef_band  <= band;
    in_bus.coef_slot  <= slot;
    in_bus.coef_value <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    case (op)
      OP_FILTER:     n_filter++;
      OP_WRITE_COEF: if (slot < NSLOT) n_coef++; else n_ignored++;
      OP_CLEAR:      n_clear++;
      default:       n_ignored++;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every expected word, then for the block to finish silent words.
  task automatic drain_pipeline;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The upper data bits of the band limit write are noise the block must drop.
  task automatic apply_setting(input logic [BAND_LIMIT_W-1:0] limit,
                               input logic [MASK_BITS-1:0] mask);
    drain_pipeline();
    write_reg(REG_BAND_LIMIT, {4'($urandom_range(0, 15)), limit});
    write_reg(REG_BAND_ENABLE, mask);
    n_settings++;
  endtask

  // Mostly moderate sections, some full-range values and some extremes.
  function automatic logic signed [COEF_IN_W-1:0] pick_coef(input logic [SLOT_SEL_W-1:0] slot);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return 32'sh1000_0000;
      endcase
    end
    if (pick < 25) return 32'($urandom);
    if (slot == SLOT_A1) return $signed($urandom_range(0, 1 << 29)) - (1 << 28);
    return $signed($urandom_range(0, 1 << 28)) - (1 << 27);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($signed($urandom_range(0, 256)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly filter words in blocks, with coefficient rewrites, clears and noise.
  task automatic send_random_word;
    int unsigned              pick;
    logic [SLOT_SEL_W-1:0]    slot;
    pick = $urandom_range(0, 99);
    slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    if (pick < 74)
      send_word(OP_FILTER, pick_sample(), $urandom_range(0, 7) == 0, 3'($urandom),
                3'($urandom), 32'($urandom));
    else if (pick < 90)
      send_word(OP_WRITE_COEF, 16'($urandom), 1'($urandom), 3'($urandom), slot,
                pick_coef(slot));
    else if (pick < 96)
      send_word(OP_CLEAR, 16'($urandom), 1'($urandom), 3'($urandom), 3'($urandom),
                32'($urandom));
    else
      send_word(OP_UNUSED, 16'($urandom), 1'($urandom), 3'($urandom), 3'($urandom),
                32'($urandom));
  endtask

  initial begin
    rst_n              = 1'b0;
    steady             = 1'b0;
    hold_pending       = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.opcode      = OP_FILTER;
    in_bus.sample_in   = '0;
    in_bus.block_end   = 1'b0;
    in_bus.coef_band   = '0;
    in_bus.coef_slot   = SLOT_B0;
    in_bus.coef_value  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.reg_index  = REG_BAND_LIMIT;
    cfg_bus.wdata      = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings apply no band: samples only go through the output scaling.
    send_word(OP_FILTER, 16'sh7FFF, 1'b0, '0, SLOT_B0, '0);
    send_word(OP_FILTER, 16'sh8000, 1'b1, '0, SLOT_B0, '0);
    send_word(OP_FILTER, 16'sd0, 1'b0, '0, SLOT_B0, '0);
    send_word(OP_FILTER, -16'sd1, 1'b1, 3'd7, 3'd7, 32'shFFFF_FFFF);
    send_word(OP_UNUSED, 16'sh7FFF, 1'b1, 3'd7, 3'd7, 32'sh7FFF_FFFF);
    send_word(OP_FILTER, 16'sd1, 1'b0, '0, SLOT_B0, '0);

    // Fill the whole coefficient table before any band is enabled.
    for (int b = 0; b < DEF_BANDS; b++)
      for (int s = 0; s < NSLOT; s++)
        send_word(OP_WRITE_COEF, '0, 1'b0, 3'(b), 3'(s), pick_coef(3'(s)));

    // Extreme coefficients in band 0 drive the signal path into saturation;
    // writes past slot a2 must leave the table alone.
    send_word(OP_WRITE_COEF, '0, 1'b0, 3'd0, SLOT_B0, 32'sh7FFF_FFFF);
    send_word(OP_WRITE_COEF, '0, 1'b0, 3'd0, SLOT_A1, 32'sh8000_0000);
    send_word(OP_WRITE_COEF, '0, 1'b0, 3'd0, 3'd5, 32'sh8000_0000);
    send_word(OP_WRITE_COEF, '0, 1'b0, 3'd0, 3'd7, 32'sh7FFF_FFFF);
    apply_setting(4'd1, 8'h01);
    send_word(OP_FILTER, 16'sh7FFF, 1'b0, '0, SLOT_B0, '0);
    send_word(OP_FILTER, 16'sh8000, 1'b0, '0, SLOT_B0, '0);
    send_word(OP_CLEAR, '0, 1'b0, '0, SLOT_B0, '0);
    send_word(OP_FILTER, 16'sh8000, 1'b1, '0, SLOT_B0, '0);

    // A band limit above the number of bands acts as all bands.
    apply_setting(4'd15, 8'hFF);
    send_word(OP_FILTER, 16'sh7FFF, 1'b0, '0, SLOT_B0, '0);
    send_word(OP_FILTER, 16'sh8000, 1'b1, '0, SLOT_B0, '0);

    // Every band skipped, then every band applied.
    apply_setting(4'd8, 8'h00);
    send_word(OP_FILTER, 16'sh1234, 1'b0, '0, SLOT_B0, '0);
    apply_setting(4'd8, 8'hFF);
    send_word(OP_FILTER, -16'sd12345, 1'b1, '0, SLOT_B0, '0);

    // Random phases, each with its own band settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(4'($urandom_range(1, 15)), 8'($urandom));
      steady = (p == STEADY_PHASE);
      if (p == HOLD_PHASE) hold_pending = 1'b1;
      repeat (WORDS_PER_PHASE) send_random_word();
    end
    steady = 1'b0;

    drain_pipeline();
    $display("Covered %0d filter words, %0d coefficient writes, %0d delay clears and %0d",
             n_filter, n_coef, n_clear, n_ignored);
    $display("ignored words over %0d band settings; %0d output words compared.",
             n_settings, checked);
    if (error_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
